// ----- sv/refcounted_entry_cache_top_defines.svh -----
// assertion macros for the entry cache
`ifndef REFCOUNTED_ENTRY_CACHE_TOP_DEFINES_SVH
`define REFCOUNTED_ENTRY_CACHE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define REC_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define REC_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define REC_ASSERT_IMP(label, clk, rst, a, c, msg)
`define REC_ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

// ----- sv/rec_pkg.sv -----
`timescale 1ns / 1ps
package rec_pkg;
  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned DEVICE_BITS_DEF = 8;
  localparam int unsigned SLOT_BITS = 6;
  localparam int unsigned OBJ_BITS = 32;
  localparam int unsigned HOLD_BITS = 16;
  localparam logic [HOLD_BITS-1:0] HOLD_MAX = '1;

  typedef enum logic [2:0] {
    K_ACQUIRE = 3'd0, K_RELEASE = 3'd1, K_FORCE = 3'd2, K_SET = 3'd3,
    K_CLEAR = 3'd4, K_RELDEV = 3'd5, K_FLUSH = 3'd6, K_FLUSH_ALL = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    ST_HIT = 4'd0, ST_NEW_EMPTY = 4'd1, ST_NEW_REPLACED = 4'd2, ST_ZERO_KEY = 4'd3,
    ST_FULL = 4'd4, ST_MOUNT = 4'd5, ST_UNDERFLOW = 4'd6, ST_NONE = 4'd7,
    ST_SATURATED = 4'd8
  } status_t;

  localparam int unsigned M_DIRTY = 0;
  localparam int unsigned M_DELETE = 1;
  localparam int unsigned M_MOUNT = 2;
  localparam int unsigned M_CUSTOM = 3;

  typedef struct packed {
    status_t                status;
    logic [SLOT_BITS-1:0]   slot;
    logic                   wb;
    logic                   fr;
    logic [HOLD_BITS-1:0]   holders;
    logic                   last;
  } result_t;
endpackage

// ----- sv/refcounted_entry_cache_top.sv -----
`timescale 1ns / 1ps
// Reference-counted lookup cache over ENTRIES entries held in one single-port-read
// synchronous memory. After reset a clearing pass zeroes every entry before the
// first request is taken. Acquire scans the table for the key and, if it is not
// found, again for a free entry, at one entry per cycle. Release device and flush
// all scan once (read, then update each entry), stalling while a held result
// cannot move to the output; each found result is held back until the next one
// is found so the final one can carry last. Results are registered and held
// until taken, and a new request is taken only once the previous one has finished.
`include "refcounted_entry_cache_top_defines.svh"
module refcounted_entry_cache_top import rec_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned DEVICE_BITS = DEVICE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // kind[2:0] device[10:3] object_number[42:11] slot[48:43]
                                // mark_bits[52:49]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // status[3:0] slot_out[9:4] write_back[10] free_object[11]
                                // holders[27:12]
  output logic        m_tlast
);
  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned W = DEVICE_BITS + OBJ_BITS + HOLD_BITS + 4;
  localparam int unsigned CW = AW + 1;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001, S_IDLE = 9'b000000010, S_RD   = 9'b000000100,
    S_ONE  = 9'b000001000, S_LOOK = 9'b000010000, S_FREE = 9'b000100000,
    S_SCAN = 9'b001000000, S_OUT  = 9'b010000000, S_NEWW = 9'b100000000
  } state_t;

  typedef struct packed {
    logic [DEVICE_BITS-1:0] dev;
    logic [OBJ_BITS-1:0]    obj;
    logic [HOLD_BITS-1:0]   hold;
    logic [3:0]             marks;
  } entry_t;

  state_t state;
  kind_t kind;
  logic [DEVICE_BITS-1:0] dev;
  logic [OBJ_BITS-1:0] obj;
  logic [SLOT_BITS-1:0] slot;
  logic [3:0] bits;
  logic [CW-1:0] idx;       // address being read
  logic rd_valid;           // memory data for rd_addr arrives
  logic [AW-1:0] rd_addr;
  logic have_empty, have_victim;
  logic [AW-1:0] empty_i, victim_i;
  logic we;
  logic [AW-1:0] waddr;
  entry_t wdata, rdata;
  logic [W-1:0] rdata_raw;
  result_t res;
  result_t pend;
  logic out_full;
  logic scan_pend;          // a scan result is held in pend

  rec_table #(.ENTRIES(ENTRIES), .DEVICE_BITS(DEVICE_BITS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(idx[AW-1:0]), .rdata(rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  assign s_tready = (state == S_IDLE) && !out_full;
  assign m_tvalid = out_full;
  assign m_tdata = {4'd0, res.holders, res.fr, res.wb, res.slot, res.status};
  assign m_tlast = res.last;

  // drop/force step on entry ei at address a; a mountpoint blocks it only when chk_mount is set (force, release device)
  function automatic void force_step(input entry_t ei, input logic [AW-1:0] a,
                                     input logic chk_mount,
                                     output entry_t eo, output result_t r);
    eo = ei;
    r = '{status: ST_HIT, slot: SLOT_BITS'(a), wb: 1'b0, fr: 1'b0, holders: '0,
          last: 1'b0};
    if (chk_mount && ei.marks[M_MOUNT]) begin
      r.status = ST_MOUNT;
      r.holders = ei.hold;
    end else begin
      eo.hold = '0;
      if (ei.marks[M_CUSTOM] || ei.marks[M_DELETE]) begin
        eo = '0;
        eo.dev = ei.dev;
        r.fr = 1'b1;
      end else if (ei.marks[M_DIRTY]) begin
        eo.marks[M_DIRTY] = 1'b0;
        r.wb = 1'b1;
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    entry_t e;
    entry_t eo;
    result_t r;
    logic [AW-1:0] a;
    logic take;
    logic of_n;
    logic we_n;
    of_n = out_full && !(m_tvalid && m_tready);
    we_n = 1'b0;
    if (rst) begin
      state <= S_CLR;
      idx <= '0;
      out_full <= 1'b0;
      scan_pend <= 1'b0;
      rd_valid <= 1'b0;
      we <= 1'b0;
    end else begin
      a = rd_addr;
      unique case (state)
        S_CLR: begin
          we_n = 1'b1;
          waddr <= idx[AW-1:0];
          wdata <= '0;
          if (idx == CW'(ENTRIES - 1)) begin
            state <= S_IDLE;
            idx <= '0;
          end else idx <= idx + 1'b1;
        end
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            kind <= kind_t'(s_tdata[2:0]);
            dev <= DEVICE_BITS'(s_tdata[10:3]);
            obj <= s_tdata[42:11];
            slot <= s_tdata[48:43];
            bits <= s_tdata[52:49];
            have_empty <= 1'b0;
            have_victim <= 1'b0;
            rd_valid <= 1'b0;
            unique case (kind_t'(s_tdata[2:0]))
              K_ACQUIRE: begin
                if (s_tdata[42:11] == '0) begin
                  res <= '{status: ST_ZERO_KEY, slot: '0, wb: 1'b0, fr: 1'b0,
                           holders: '0, last: 1'b1};
                  of_n = 1'b1;
                end else begin
                  idx <= '0;
                  state <= S_LOOK;
                end
              end
              K_RELDEV, K_FLUSH_ALL: begin
                idx <= '0;
                state <= S_SCAN;
              end
              default: begin
                if (32'(s_tdata[48:43]) >= ENTRIES) begin
                  res <= '{status: ST_NONE, slot: s_tdata[48:43], wb: 1'b0, fr: 1'b0,
                           holders: '0, last: 1'b1};
                  of_n = 1'b1;
                end else begin
                  idx <= CW'(s_tdata[48:43]);
                  state <= S_RD;
                end
              end
            endcase
          end
        end
        S_RD: state <= S_ONE;
        S_ONE: begin
          e = rdata;
          a = idx[AW-1:0];
          eo = e;
          r = '{status: ST_HIT, slot: slot, wb: 1'b0, fr: 1'b0, holders: e.hold,
                last: 1'b1};
          if (e.obj == '0) begin
            r.status = ST_NONE;
            r.holders = '0;
          end else begin
            unique case (kind)
              K_RELEASE: begin
                if (e.hold == '0) r.status = ST_UNDERFLOW;
                else if (e.hold == HOLD_BITS'(1)) begin
                  force_step(e, a, 1'b0, eo, r);
                  r.last = 1'b1;
                end else begin
                  eo.hold = e.hold - 1'b1;
                  r.holders = eo.hold;
                end
              end
              K_FORCE: begin
                force_step(e, a, 1'b1, eo, r);
                r.last = 1'b1;
              end
              K_SET: eo.marks = e.marks | bits;
              K_CLEAR: eo.marks = e.marks & ~bits;
              default: begin
                r.wb = e.marks[M_DIRTY];
                eo.marks[M_DIRTY] = 1'b0;
              end
            endcase
          end
          we_n = 1'b1;
          waddr <= a;
          wdata <= eo;
          res <= r;
          of_n = 1'b1;
          state <= S_IDLE;
        end
        S_LOOK: begin
          // lookup pass: address idx issued, data for rd_addr (a) valid when rd_valid
          if (rd_valid && rdata.obj != '0 && rdata.obj == obj && rdata.dev == dev) begin
            eo = rdata;
            r = '{status: ST_HIT, slot: SLOT_BITS'(a), wb: 1'b0, fr: 1'b0,
                  holders: rdata.hold, last: 1'b1};
            if (rdata.hold == HOLD_MAX) r.status = ST_SATURATED;
            else begin
              eo.hold = rdata.hold + 1'b1;
              r.holders = eo.hold;
            end
            we_n = 1'b1;
            waddr <= a;
            wdata <= eo;
            res <= r;
            of_n = 1'b1;
            rd_valid <= 1'b0;
            state <= S_IDLE;
          end else if (rd_valid && a == AW'(ENTRIES - 1)) begin
            idx <= '0;
            rd_valid <= 1'b0;
            state <= S_FREE;
          end else begin
            rd_addr <= idx[AW-1:0];
            rd_valid <= 1'b1;
            if (idx != CW'(ENTRIES - 1)) idx <= idx + 1'b1;
          end
        end
        S_FREE: begin
          if (rd_valid) begin
            if (rdata.obj == '0) begin
              if (!have_empty) begin
                have_empty <= 1'b1;
                empty_i <= a;
              end
            end else if (rdata.hold == '0) begin
              have_victim <= 1'b1;
              victim_i <= a;
            end
          end
          if (rd_valid && a == AW'(ENTRIES - 1)) begin
            rd_valid <= 1'b0;
            state <= S_NEWW;
          end else begin
            rd_addr <= idx[AW-1:0];
            rd_valid <= 1'b1;
            if (idx != CW'(ENTRIES - 1)) idx <= idx + 1'b1;
          end
        end
        S_NEWW: begin
          r = '{status: ST_FULL, slot: '0, wb: 1'b0, fr: 1'b0, holders: '0, last: 1'b1};
          if (have_empty || have_victim) begin
            a = have_empty ? empty_i : victim_i;
            r.status = have_empty ? ST_NEW_EMPTY : ST_NEW_REPLACED;
            r.slot = SLOT_BITS'(a);
            r.holders = HOLD_BITS'(1);
            we_n = 1'b1;
            waddr <= a;
            wdata <= '{dev: dev, obj: obj, hold: HOLD_BITS'(1), marks: 4'd0};
          end
          res <= r;
          of_n = 1'b1;
          state <= S_IDLE;
        end
        S_SCAN: begin
          // read, then update; stall while a held result cannot move to the output
          if (rd_valid) begin
            e = rdata;
            eo = e;
            take = 1'b0;
            r = '{status: ST_HIT, slot: SLOT_BITS'(a), wb: 1'b1, fr: 1'b0,
                  holders: e.hold, last: 1'b0};
            if (e.obj != '0) begin
              if (kind == K_RELDEV) begin
                if (e.dev == dev) begin
                  take = 1'b1;
                  force_step(e, a, 1'b1, eo, r);
                end
              end else if (e.marks[M_DIRTY]) begin
                take = 1'b1;
                eo.marks[M_DIRTY] = 1'b0;
              end
            end
            if (!(take && scan_pend && of_n)) begin
              if (take) begin
                we_n = 1'b1;
                waddr <= a;
                wdata <= eo;
                if (scan_pend) begin
                  res <= pend;
                  of_n = 1'b1;
                end
                pend <= r;
                scan_pend <= 1'b1;
              end
              rd_valid <= 1'b0;
              if (a == AW'(ENTRIES - 1)) state <= S_OUT;
              else idx <= idx + 1'b1;
            end
          end else begin
            rd_addr <= idx[AW-1:0];
            rd_valid <= 1'b1;
          end
        end
        S_OUT: begin
          // the held result goes out last, or none when nothing was found
          if (!of_n) begin
            if (scan_pend) begin
              r = pend;
              r.last = 1'b1;
              res <= r;
            end else begin
              res <= '{status: ST_NONE, slot: '0, wb: 1'b0, fr: 1'b0, holders: '0,
                       last: 1'b1};
            end
            of_n = 1'b1;
            scan_pend <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      out_full <= of_n;
      we <= we_n;
    end
  end

  `REC_ASSERT_IMP(a_idle_ready, clk, rst, s_tready, state == S_IDLE, "ready outside idle")
  `REC_ASSERT_NEXT(a_accept_busy, clk, rst, s_tvalid && s_tready, !s_tready,
                   "second request taken at once")
  `REC_ASSERT_IMP(a_write_in_range, clk, rst, we, 32'(waddr) < ENTRIES,
                  "table write out of range")
endmodule

// ----- sv/rec_table.sv -----
`timescale 1ns / 1ps
// entry store: one write port, one registered read port
module rec_table import rec_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned DEVICE_BITS = DEVICE_BITS_DEF,
  localparam int unsigned AW = $clog2(ENTRIES),
  localparam int unsigned W = DEVICE_BITS + OBJ_BITS + HOLD_BITS + 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top import rec_pkg::*; ();

  localparam int NSLOTS = ENTRIES_DEF;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct packed {
    status_t          status;
    logic [5:0]       slot;
    logic             wb;
    logic             fr;
    logic [15:0]      holders;
    logic             last;
  } cache_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  refcounted_entry_cache_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the table
  logic [7:0]  tab_dev [NSLOTS];
  logic [31:0] tab_obj [NSLOTS];
  logic [15:0] tab_hold [NSLOTS];
  logic [3:0]  tab_marks [NSLOTS];

  cache_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic cache_result_t mk(status_t st, int s, bit wb, bit fr,
                                       logic [15:0] h);
    cache_result_t r;
    r.status = st; r.slot = s[5:0]; r.wb = wb; r.fr = fr; r.holders = h; r.last = 1'b0;
    return r;
  endfunction

  function automatic void push_drop(int i);
    if (tab_marks[i][M_CUSTOM] || tab_marks[i][M_DELETE]) begin
      tab_obj[i] = '0; tab_hold[i] = '0; tab_marks[i] = '0;
      pending_results.push_back(mk(ST_HIT, i, 0, 1, 0));
    end else if (tab_marks[i][M_DIRTY]) begin
      tab_marks[i][M_DIRTY] = 1'b0;
      pending_results.push_back(mk(ST_HIT, i, 1, 0, 0));
    end else begin
      pending_results.push_back(mk(ST_HIT, i, 0, 0, 0));
    end
  endfunction

  function automatic void push_force(int i);
    if (tab_marks[i][M_MOUNT]) begin
      pending_results.push_back(mk(ST_MOUNT, i, 0, 0, tab_hold[i]));
    end else begin
      tab_hold[i] = '0;
      push_drop(i);
    end
  endfunction

  function automatic void predict_request(kind_t k, logic [7:0] dev, logic [31:0] obj,
                                          logic [5:0] s, logic [3:0] bits);
    int base;
    int empty_at;
    int victim_at;
    bit done;
    base = pending_results.size();
    done = 1'b0;
    empty_at = -1;
    victim_at = -1;
    case (k)
      K_ACQUIRE: begin
        if (obj == 0) begin
          pending_results.push_back(mk(ST_ZERO_KEY, 0, 0, 0, 0));
          done = 1'b1;
        end
        for (int i = 0; i < NSLOTS && !done; i++) begin
          if (tab_obj[i] != 0 && tab_obj[i] == obj && tab_dev[i] == dev) begin
            done = 1'b1;
            if (tab_hold[i] == HOLD_MAX) begin
              pending_results.push_back(mk(ST_SATURATED, i, 0, 0, HOLD_MAX));
            end else begin
              tab_hold[i]++;
              pending_results.push_back(mk(ST_HIT, i, 0, 0, tab_hold[i]));
            end
          end
        end
        if (!done) begin
          for (int i = 0; i < NSLOTS; i++) begin
            if (tab_obj[i] == 0) begin
              if (empty_at < 0) empty_at = i;
            end else if (tab_hold[i] == 0) begin
              victim_at = i;
            end
          end
          if (empty_at < 0 && victim_at < 0) begin
            pending_results.push_back(mk(ST_FULL, 0, 0, 0, 0));
          end else begin
            int i;
            i = (empty_at >= 0) ? empty_at : victim_at;
            tab_dev[i] = dev; tab_obj[i] = obj; tab_hold[i] = 1; tab_marks[i] = '0;
            pending_results.push_back(mk((empty_at >= 0) ? ST_NEW_EMPTY : ST_NEW_REPLACED,
                                         i, 0, 0, 1));
          end
        end
      end
      K_RELDEV, K_FLUSH_ALL: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (tab_obj[i] != 0) begin
            if (k == K_RELDEV) begin
              if (tab_dev[i] == dev) push_force(i);
            end else if (tab_marks[i][M_DIRTY]) begin
              tab_marks[i][M_DIRTY] = 1'b0;
              pending_results.push_back(mk(ST_HIT, i, 1, 0, tab_hold[i]));
            end
          end
        end
        if (pending_results.size() == base)
          pending_results.push_back(mk(ST_NONE, 0, 0, 0, 0));
      end
      default: begin
        if (s >= NSLOTS || tab_obj[s] == 0) begin
          pending_results.push_back(mk(ST_NONE, s, 0, 0, 0));
        end else if (k == K_RELEASE) begin
          if (tab_hold[s] == 0) begin
            pending_results.push_back(mk(ST_UNDERFLOW, s, 0, 0, 0));
          end else begin
            tab_hold[s]--;
            if (tab_hold[s] == 0) push_drop(s);
            else pending_results.push_back(mk(ST_HIT, s, 0, 0, tab_hold[s]));
          end
        end else if (k == K_FORCE) begin
          push_force(s);
        end else if (k == K_SET || k == K_CLEAR) begin
          if (k == K_SET) tab_marks[s] = tab_marks[s] | bits;
          else tab_marks[s] = tab_marks[s] & ~bits;
          pending_results.push_back(mk(ST_HIT, s, 0, 0, tab_hold[s]));
        end else begin
          bit wb;
          wb = tab_marks[s][M_DIRTY];
          tab_marks[s][M_DIRTY] = 1'b0;
          pending_results.push_back(mk(ST_HIT, s, wb, 0, tab_hold[s]));
        end
      end
    endcase
    pending_results[pending_results.size() - 1].last = 1'b1;
  endfunction

  // sender: bursts with random gaps between them
  task automatic send_request(kind_t k, logic [7:0] dev, logic [31:0] obj,
                              logic [5:0] s, logic [3:0] bits);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    predict_request(k, dev, obj, s, bits);
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, bits, s, obj, dev, k};
    do @(posedge clk); while (!s_tready);
  endtask

  // receiver stall pattern: phases of always ready, random, and long stalls
  always @(posedge clk) begin
    case ((cycles / 300) % 3)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 2) != 0);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    cache_result_t want;
    cycles++;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[3:0] != want.status)
          report_mismatch($sformatf("status %0d want %0d", m_tdata[3:0], want.status));
        if (m_tdata[9:4] != want.slot)
          report_mismatch($sformatf("slot %0d want %0d", m_tdata[9:4], want.slot));
        if (m_tdata[10] != want.wb)
          report_mismatch($sformatf("write_back %0b want %0b", m_tdata[10], want.wb));
        if (m_tdata[11] != want.fr)
          report_mismatch($sformatf("free_object %0b want %0b", m_tdata[11], want.fr));
        if (m_tdata[27:12] != want.holders)
          report_mismatch($sformatf("holders %0d want %0d", m_tdata[27:12], want.holders));
        if (m_tlast != want.last)
          report_mismatch($sformatf("last %0b want %0b", m_tlast, want.last));
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_obj();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 6);
      1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_request(K_ACQUIRE, 8'd0, 32'd0, 6'd0, 4'd0);           // zero key
    send_request(K_RELDEV, 8'd3, 32'd0, 6'd0, 4'd0);            // nothing to report
    send_request(K_FLUSH_ALL, 8'd0, 32'd0, 6'd0, 4'd0);
    send_request(K_RELEASE, 8'd0, 32'd0, 6'd63, 4'd0);          // empty slot
    send_request(K_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 6'd0, 4'd0);
    send_request(K_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 6'd0, 4'd0);  // hit
    send_request(K_ACQUIRE, 8'd0, 32'd1, 6'd0, 4'd0);
    send_request(K_SET, 8'd0, 32'd0, 6'd0, 4'hF);
    send_request(K_FORCE, 8'd0, 32'd0, 6'd0, 4'd0);             // mountpoint
    send_request(K_CLEAR, 8'd0, 32'd0, 6'd0, 4'b0100);
    send_request(K_FLUSH_ALL, 8'd0, 32'd0, 6'd0, 4'd0);
    send_request(K_RELEASE, 8'd0, 32'd0, 6'd0, 4'd0);
    send_request(K_RELEASE, 8'd0, 32'd0, 6'd0, 4'd0);           // freed
    send_request(K_SET, 8'd0, 32'd0, 6'd1, 4'b0001);
    send_request(K_FLUSH, 8'd0, 32'd0, 6'd1, 4'd0);
    send_request(K_RELEASE, 8'd0, 32'd0, 6'd1, 4'd0);
    send_request(K_RELEASE, 8'd0, 32'd0, 6'd1, 4'd0);           // underflow
    send_request(K_SET, 8'd0, 32'd0, 6'd1, 4'b0101);
    send_request(K_RELDEV, 8'd0, 32'd0, 6'd0, 4'd0);
    send_request(K_CLEAR, 8'd0, 32'd0, 6'd1, 4'hF);
    send_request(K_RELDEV, 8'd0, 32'd0, 6'd0, 4'd0);
  endtask

  // fill every entry held, then one more acquire reports full, then a replace
  task automatic test_full_and_replace();
    for (int i = 0; i < NSLOTS; i++)
      send_request(K_ACQUIRE, 8'd9, 32'h1000 + i, 6'd0, 4'd0);
    send_request(K_ACQUIRE, 8'd9, 32'h2000, 6'd0, 4'd0);
    send_request(K_RELEASE, 8'd0, 32'd0, 6'd5, 4'd0);
    send_request(K_RELEASE, 8'd0, 32'd0, 6'd40, 4'd0);
    send_request(K_ACQUIRE, 8'd9, 32'h2001, 6'd0, 4'd0);
    send_request(K_RELDEV, 8'd9, 32'd0, 6'd0, 4'd0);
  endtask

  // drive one entry to the holder limit through the table itself is too slow,
  // so saturation is not reached here; instead send random requests, weighted toward
  // acquires on keys that often repeat, to show counting stays in step
  task automatic test_random();
    for (int n = 0; n < 500; n++) begin
      kind_t k;
      logic [7:0] dev;
      logic [5:0] s;
      k = kind_t'($urandom_range(0, 7));
      if ($urandom_range(0, 9) < 4) k = K_ACQUIRE;
      if (k == K_RELDEV && $urandom_range(0, 1)) k = K_RELEASE;
      dev = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
      s = ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 7));
      send_request(k, dev, ($urandom_range(0, 19) == 0) ? 32'd0 : rand_obj(), s,
                   4'($urandom()));
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      tab_dev[i] = '0; tab_obj[i] = '0; tab_hold[i] = '0; tab_marks[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_and_replace();
    test_random();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
